>>> design/ffha_pkg.sv
// shared constants for the first-fit heap allocator
// field widths, operation and status codes, default heap size
package ffha_pkg;

   localparam int HEAP_WORDS_DEF = 1024;
   localparam int ADDR_W = 10;
   localparam int FUNC_W = 1;
   localparam int STATUS_W = 1;
   localparam int NEED_W = ADDR_W + 1;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 1'b0;
   localparam logic [STATUS_W-1:0] STATUS_OOM = 1'b1;

endpackage

>>> design/first_fit_heap_allocator.sv
// Circular first-fit heap allocator: one request at a time, busy high while working.
// A free clears the busy flag in the block's header; address zero or one outside the heap is answered
// without a header read. An allocate walks the headers from the search pointer, passing over busy ones
// and free ones that are too small, and merges each run of free blocks ahead before testing for a fit;
// out of memory is answered once the last header is passed.
// The result appears for one cycle on rsp_strobe and is not held, so it must be taken then.
// After reset, busy stays high while the header memory is initialized.
// top level; uses ffha_pkg and ffha_hdr_store
module first_fit_heap_allocator #(
   parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ffha_pkg::FUNC_W-1:0]    req_func,
   input  logic [ffha_pkg::ADDR_W-1:0]    req_request_words,
   input  logic [ffha_pkg::ADDR_W-1:0]    req_block_address,
   output logic                           rsp_strobe,
   output logic [ffha_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ffha_pkg::ADDR_W-1:0]    rsp_address
);
   import ffha_pkg::*;

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int HW = AW + 1;
   localparam int SW = ((AW > NEED_W) ? AW : NEED_W) + 1;
   localparam logic [AW-1:0] TOP = AW'(HEAP_WORDS - 1);
   localparam logic [SW-1:0] TOP_X = SW'(HEAP_WORDS - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FREE  = 3'd1;
   localparam logic [2:0] ST_CHK_P = 3'd2;
   localparam logic [2:0] ST_CHK_Q = 3'd3;
   localparam logic [2:0] ST_FIT   = 3'd4;
   localparam logic [2:0] ST_ALLOC = 3'd5;
   localparam logic [2:0] ST_ADV   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [AW-1:0]       p_ff, p_in;
   logic [AW-1:0]       q_ff, q_in;
   logic [AW-1:0]       sp_ff, sp_in;
   logic [NEED_W-1:0]   need_ff, need_in;
   logic                wraps_ff, wraps_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_address_ff, rsp_address_in;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [HW-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [HW-1:0] wr_data;
   logic          init_done;

   logic          hdr_busy;
   logic [AW-1:0] hdr_link;
   logic [SW-1:0] split;
   logic [SW-1:0] p_plus;
   logic [SW-1:0] baddr_x;
   logic          accept;
   logic          fits;

   ffha_hdr_store #(
      .HEAP_WORDS(HEAP_WORDS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .init_done(init_done)
   );

   assign busy = (state_ff != ST_IDLE) || !init_done;
   assign accept = start && !busy;
   assign hdr_busy = rd_data[AW];
   assign hdr_link = rd_data[AW-1:0];
   assign split = SW'(p_ff) + SW'(need_ff);
   assign p_plus = SW'(p_ff) + SW'(1);
   assign baddr_x = SW'(req_block_address);
   assign fits = (q_ff > p_ff) && (q_ff <= TOP) && (SW'(q_ff) >= split);

   always_comb begin
      state_in = state_ff;
      p_in = p_ff;
      q_in = q_ff;
      sp_in = sp_ff;
      need_in = need_ff;
      wraps_in = wraps_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_address_in = '0;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_FREE) begin
                  if (req_block_address != '0 && baddr_x <= TOP_X) begin
                     p_in = AW'(baddr_x - SW'(1));
                     rd_en = 1'b1;
                     rd_addr = p_in;
                     state_in = ST_FREE;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end else begin
                  // a zero request still takes one payload word
                  need_in = ((req_request_words == '0) ? NEED_W'(1)
                            : NEED_W'(req_request_words)) + NEED_W'(1);
                  p_in = sp_ff;
                  wraps_in = 1'b0;
                  rd_en = 1'b1;
                  rd_addr = sp_ff;
                  state_in = ST_CHK_P;
               end
            end
         end
         ST_FREE: begin
            wr_en = 1'b1;
            wr_addr = p_ff;
            wr_data = {1'b0, hdr_link};
            sp_in = p_ff;
            rsp_strobe_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CHK_P: begin
            q_in = hdr_link;
            if (hdr_busy) begin
               state_in = ST_ADV;
            end else if (hdr_link > p_ff && hdr_link < TOP) begin
               rd_en = 1'b1;
               rd_addr = hdr_link;
               state_in = ST_CHK_Q;
            end else begin
               state_in = ST_FIT;
            end
         end
         ST_CHK_Q: begin
            // absorb the following free block when its link runs forward
            if (!hdr_busy && hdr_link > q_ff && hdr_link <= TOP) begin
               wr_en = 1'b1;
               wr_addr = p_ff;
               wr_data = {1'b0, hdr_link};
               q_in = hdr_link;
               if (hdr_link < TOP) begin
                  rd_en = 1'b1;
                  rd_addr = hdr_link;
               end else begin
                  state_in = ST_FIT;
               end
            end else begin
               state_in = ST_FIT;
            end
         end
         ST_FIT: begin
            if (fits) begin
               if (SW'(q_ff) > split) begin
                  wr_en = 1'b1;
                  wr_addr = AW'(split);
                  wr_data = {1'b0, q_ff};
               end
               state_in = ST_ALLOC;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_ALLOC: begin
            wr_en = 1'b1;
            wr_addr = p_ff;
            wr_data = {1'b1, AW'(split)};
            sp_in = AW'(split);
            rsp_strobe_in = 1'b1;
            rsp_address_in = p_plus[ADDR_W-1:0];
            state_in = ST_IDLE;
         end
         ST_ADV: begin
            // only the top to word 0 link may go backward, and only once
            if ((q_ff > p_ff) ? (q_ff > TOP)
                : (p_ff != TOP || q_ff != '0 || wraps_ff)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OOM;
               state_in = ST_IDLE;
            end else begin
               wraps_in = wraps_ff || (q_ff <= p_ff);
               p_in = q_ff;
               rd_en = 1'b1;
               rd_addr = q_ff;
               state_in = ST_CHK_P;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      q_ff <= q_in;
      need_ff <= need_in;
      wraps_ff <= wraps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_address_ff <= rsp_address_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

   // every accepted request either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("accepted request neither answered nor in progress");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result given while still busy");

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= TOP)
      else $error("search pointer beyond top");

   // merge walk only ever moves forward of the block being grown
   a_merge_forward: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK_Q) |-> (q_ff > p_ff))
      else $error("merge candidate not ahead of current block");

endmodule

>>> design/ffha_hdr_store.sv
// block header memory of the heap allocator, one read and one write port
// sweeps every entry to its initial value after reset; uses ffha_pkg
module ffha_hdr_store #(
   parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
   localparam int AW = $clog2(HEAP_WORDS),
   localparam int HW = AW + 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [HW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [HW-1:0] wr_data,
   output logic          init_done
);
   import ffha_pkg::*;

   localparam logic [AW-1:0] TOP = AW'(HEAP_WORDS - 1);

   logic [HW-1:0] mem [HEAP_WORDS];
   logic [HW-1:0] rd_data_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] clr_in;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   logic [HW-1:0] clr_value;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [HW-1:0] mem_wd;

   // word 0 is one free block up to top, top is the busy end marker
   always_comb begin
      if (clr_ff == '0) begin
         clr_value = {1'b0, TOP};
      end else if (clr_ff == TOP) begin
         clr_value = {1'b1, {AW{1'b0}}};
      end else begin
         clr_value = '0;
      end
   end

   always_comb begin
      clr_in = clr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_in = clr_ff + AW'(1);
         if (clr_ff == TOP) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (clr_busy_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_ff;
         mem_wd = clr_value;
      end else begin
         mem_we = wr_en;
         mem_wa = wr_addr;
         mem_wd = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_ff <= clr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign init_done = !clr_busy_ff;

endmodule

>>> verif/tb_top.sv
// testbench for first_fit_heap_allocator: directed corner cases, fill and release, random traffic
// keeps its own copy of the header store and search pointer and checks every response against it
// depends on ffha_pkg and the allocator rtl
module tb_top;
   import ffha_pkg::*;

   localparam int HEAP_SIZE = HEAP_WORDS_DEF;
   localparam int TOP_HDR = HEAP_SIZE - 1;
   localparam longint RUN_LIMIT = 64'd200_000_000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   address;
   } heap_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FUNC_W-1:0]   req_func = FUNC_ALLOC;
   logic [ADDR_W-1:0]   req_request_words = '0;
   logic [ADDR_W-1:0]   req_block_address = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_address;

   // predicted heap: bit ADDR_W is the busy flag, the rest the next-header link
   logic [ADDR_W:0]     heap_hdr [HEAP_SIZE];
   int                  rover;
   logic [ADDR_W-1:0]   granted_blocks [$];
   heap_result_type     pending_results [$];

   int idle_pct = 0;
   int mismatches = 0;
   int checked = 0;
   int alloc_count = 0;
   int free_count = 0;
   int oom_count = 0;
   bit last_alloc_oom = 1'b0;

   first_fit_heap_allocator uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_request_words (req_request_words),
      .req_block_address (req_block_address),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_address       (rsp_address)
   );

   always #10 clock = ~clock;

   function automatic void reset_heap_model();
      int i;
      for (i = 0; i < HEAP_SIZE; i++) begin
         heap_hdr[i] = '0;
      end
      heap_hdr[0] = {1'b0, TOP_HDR[ADDR_W-1:0]};
      heap_hdr[TOP_HDR] = {1'b1, {ADDR_W{1'b0}}};
      rover = 0;
      granted_blocks.delete();
   endfunction

   function automatic heap_result_type predict_heap_request(input logic [FUNC_W-1:0] f,
                                                            input logic [ADDR_W-1:0] words,
                                                            input logic [ADDR_W-1:0] baddr);
      heap_result_type res;
      int need, p, q, prev, nxt, split, wraps, h, i;
      logic [ADDR_W:0] e;
      res.status = STATUS_OK;
      res.address = '0;
      if (f == FUNC_FREE) begin
         if (baddr != '0) begin
            h = int'(baddr) - 1;
            heap_hdr[h][ADDR_W] = 1'b0;
            rover = h;
            for (i = 0; i < granted_blocks.size(); i++) begin
               if (granted_blocks[i] == baddr) begin
                  granted_blocks.delete(i);
                  break;
               end
            end
         end
         return res;
      end
      need = ((words == '0) ? 1 : int'(words)) + 1;
      p = rover;
      wraps = 0;
      forever begin
         e = heap_hdr[p];
         if (!e[ADDR_W]) begin
            q = int'(e[ADDR_W-1:0]);
            // absorb a run of free blocks that lie ahead
            while (q > p && q < TOP_HDR && !heap_hdr[q][ADDR_W]) begin
               nxt = int'(heap_hdr[q][ADDR_W-1:0]);
               if (nxt <= q) break;
               heap_hdr[p] = {1'b0, nxt[ADDR_W-1:0]};
               q = nxt;
            end
            if (q > p && q >= p + need) begin
               split = p + need;
               if (q > split) heap_hdr[split] = {1'b0, q[ADDR_W-1:0]};
               heap_hdr[p] = {1'b1, split[ADDR_W-1:0]};
               rover = split;
               h = p + 1;
               res.address = h[ADDR_W-1:0];
               granted_blocks.push_back(res.address);
               return res;
            end
         end
         prev = p;
         p = int'(heap_hdr[prev][ADDR_W-1:0]);
         if (p <= prev) begin
            // only the top-to-zero link may go backward, and only once
            if (prev != TOP_HDR || p != 0) break;
            wraps++;
            if (wraps > 1) break;
         end
      end
      res.status = STATUS_OOM;
      return res;
   endfunction

   // response check first, then prediction for a request taken at this edge
   always @(posedge clock) begin
      heap_result_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            checked++;
            if (pending_results.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected response: status %0d address %0d", rsp_status,
                           rsp_address);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status || rsp_address !== want.address) begin
                  if (mismatches < 10)
                     $display("mismatch: expected status %0d address %0d, got %0d %0d",
                              want.status, want.address, rsp_status, rsp_address);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            want = predict_heap_request(req_func, req_request_words, req_block_address);
            pending_results.push_back(want);
            if (req_func == FUNC_FREE) begin
               free_count++;
            end else begin
               alloc_count++;
               last_alloc_oom = (want.status == STATUS_OOM);
               if (last_alloc_oom) oom_count++;
            end
         end
      end
   end

   task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] words,
                               input logic [ADDR_W-1:0] baddr);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_func = f;
      req_request_words = words;
      req_block_address = baddr;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic release_granted();
      int idx;
      while (granted_blocks.size() > 0) begin
         idx = $urandom_range(granted_blocks.size() - 1);
         send_request(FUNC_FREE, ADDR_W'($urandom), granted_blocks[idx]);
      end
   endtask

   task automatic run_directed();
      idle_pct = 0;
      send_request(FUNC_ALLOC, 10'd1022, 10'd0);      // exact fit of the whole heap
      send_request(FUNC_ALLOC, 10'd0, 10'h3FF);       // no room, the second wrap ends the search
      send_request(FUNC_FREE, 10'h3FF, 10'd1);
      send_request(FUNC_ALLOC, 10'd1023, 10'd0);      // larger than the heap
      send_request(FUNC_ALLOC, 10'd0, 10'd0);         // zero taken as one word
      send_request(FUNC_ALLOC, 10'd1, 10'd0);
      send_request(FUNC_ALLOC, 10'd1021, 10'd0);
      send_request(FUNC_FREE, 10'd5, 10'd0);          // address zero is ignored
      send_request(FUNC_FREE, 10'd0, 10'd1);
      send_request(FUNC_FREE, 10'd0, 10'd3);
      send_request(FUNC_ALLOC, 10'd1021, 10'd0);      // merges free runs, fits after wrap
      send_request(FUNC_FREE, 10'd0, 10'd1023);       // highest address, frees the tail
      send_request(FUNC_ALLOC, 10'd0, 10'd0);
      send_request(FUNC_FREE, 10'd0, 10'd512);        // payload word with a zero link
      send_request(FUNC_ALLOC, 10'd5, 10'd0);         // broken chain ends the search
      send_request(FUNC_FREE, 10'd0, 10'd1);
      send_request(FUNC_ALLOC, 10'd1000, 10'd0);
      send_request(FUNC_ALLOC, 10'd20, 10'd0);
      send_request(FUNC_ALLOC, 10'h155, 10'h2AA);
      send_request(FUNC_ALLOC, 10'h2AA, 10'h155);
      release_granted();
      drain_results();
   endtask

   task automatic run_fill_and_release();
      int k;
      idle_pct = 0;
      last_alloc_oom = 1'b0;
      k = 0;
      while (!last_alloc_oom && k < 150) begin
         send_request(FUNC_ALLOC, ADDR_W'($urandom_range(16, 4)), ADDR_W'($urandom));
         k++;
      end
      send_request(FUNC_ALLOC, 10'd0, ADDR_W'($urandom));
      idle_pct = 22;
      release_granted();
      drain_results();
   endtask

   task automatic run_random_traffic(input int count, input int pct);
      int n, r, s, idx;
      logic [ADDR_W-1:0] words, baddr;
      idle_pct = pct;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         words = ADDR_W'($urandom);
         baddr = ADDR_W'($urandom);
         if (r < 3) begin
            // stray free anywhere in the heap
            send_request(FUNC_FREE, words, baddr);
         end else if (r < 50 && granted_blocks.size() > 0) begin
            idx = $urandom_range(granted_blocks.size() - 1);
            send_request(FUNC_FREE, words, granted_blocks[idx]);
         end else begin
            s = $urandom_range(99);
            if (s < 70) words = ADDR_W'($urandom_range(24));
            else if (s < 92) words = ADDR_W'($urandom_range(150, 25));
            else if (s < 98) words = ADDR_W'($urandom_range(600, 151));
            send_request(FUNC_ALLOC, words, baddr);
         end
      end
      drain_results();
   endtask

   initial begin
      reset_heap_model();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      run_directed();
      run_fill_and_release();
      run_random_traffic(150, 0);
      run_random_traffic(150, 68);
      run_random_traffic(140, 22);
      if (pending_results.size() != 0) begin
         $display("%0d responses never arrived", pending_results.size());
         mismatches += pending_results.size();
      end
      $display("covered %0d allocates (%0d out of memory) and %0d frees, %0d responses checked",
               alloc_count, oom_count, free_count, checked);
      $display("phases: directed corners, heap fill and release, random traffic with gaps");
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

>>> files.f
design/ffha_pkg.sv
design/ffha_hdr_store.sv
design/first_fit_heap_allocator.sv
verif/tb_top.sv
